// ----- rtl/scfd_pkg.sv -----
// ----------------------------------------------------------------------------
// scfd_pkg
// Shared constants and controller/datapath interface types for the sync-word
// frame deframer with CRC-16/CCITT-FALSE check.
// ----------------------------------------------------------------------------
package scfd_pkg;

   // Frame layout
   localparam int JOINTS        = 14;   // joint results emitted per good frame
   localparam int VALUE_SLOTS   = 14;   // joint values carried in a frame
   localparam int TIME_BYTES    = 8;
   localparam int PAYLOAD_BYTES = 36;   // bytes covered by the CRC
   localparam int BODY_BYTES    = 38;   // payload plus two CRC bytes

   localparam logic [7:0]  SYNC_LO  = 8'h55;
   localparam logic [7:0]  SYNC_HI  = 8'hAA;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // Widths
   localparam int POS_W   = 6;   // body byte counter
   localparam int IDX_W   = 4;   // joint index field
   localparam int LANE_W  = 3;   // byte lane inside the timestamp
   localparam int TIME_W  = 64;
   localparam int VALUE_W = 16;

   // Result tdata packing, lowest bit first
   localparam int TD_TIME_LSB  = 0;
   localparam int TD_IDX_LSB   = TD_TIME_LSB + TIME_W;
   localparam int TD_VALUE_LSB = TD_IDX_LSB + IDX_W;
   localparam int TD_USED_W    = TD_VALUE_LSB + VALUE_W;
   localparam int RSP_TDATA_W  = ((TD_USED_W + 7) / 8) * 8;

   // Controller to datapath commands
   typedef struct packed {
      logic              crc_clear;    // restart the running CRC
      logic              crc_update;   // fold the request byte into the CRC
      logic              time_wr;      // store request byte into a timestamp lane
      logic [LANE_W-1:0] time_lane;
      logic              val_wr;       // store request byte into a joint value
      logic [IDX_W-1:0]  val_slot;
      logic              val_hi;       // 1: upper byte of the value
      logic              crc_lo_wr;    // hold the received CRC low byte
      logic              emit_load;    // load one result into the output register
      logic [IDX_W-1:0]  emit_index;
      logic              emit_last;
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic sync_lo;     // request byte is the first sync byte
      logic sync_hi;     // request byte is the second sync byte
      logic crc_match;   // {request byte, held low byte} equals running CRC
      logic out_free;    // output register can take a result this cycle
   } dp_status_type;

endpackage

// ----- rtl/scfd_ctrl.sv -----
// ----------------------------------------------------------------------------
// scfd_ctrl
// Frame controller: sync hunt, body byte sequencing and result emission.
// ----------------------------------------------------------------------------
module scfd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  scfd_pkg::dp_status_type status,
   output scfd_pkg::ctrl_cmd_type  cmd
);
   import scfd_pkg::*;

   localparam logic [1:0] ST_HUNT  = 2'd0;
   localparam logic [1:0] ST_SYNC2 = 2'd1;
   localparam logic [1:0] ST_BODY  = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(PAYLOAD_BYTES);
   localparam logic [POS_W-1:0] POS_LAST   = POS_W'(BODY_BYTES - 1);
   localparam logic [POS_W-1:0] POS_TIME   = POS_W'(TIME_BYTES);
   localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(JOINTS - 1);
   localparam logic [POS_W-2:0] SLOT_BASE  = (POS_W-1)'(TIME_BYTES / 2);

   logic [1:0]       state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             accept;

   assign req_tready = (state_ff != ST_EMIT);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      idx_in   = idx_ff;

      cmd            = '0;
      cmd.time_lane  = pos_ff[LANE_W-1:0];
      cmd.val_slot   = IDX_W'(pos_ff[POS_W-1:1] - SLOT_BASE);
      cmd.val_hi     = pos_ff[0];
      cmd.emit_index = idx_ff;
      cmd.emit_last  = (idx_ff == IDX_LAST);

      unique case (state_ff)
         ST_HUNT: begin
            if (accept) begin
               state_in = status.sync_lo ? ST_SYNC2 : ST_HUNT;
            end
         end
         ST_SYNC2: begin
            // A wrong second byte is dropped, not rechecked as a first sync byte
            if (accept) begin
               if (status.sync_hi) begin
                  state_in      = ST_BODY;
                  pos_in        = '0;
                  cmd.crc_clear = 1'b1;
               end else begin
                  state_in = ST_HUNT;
               end
            end
         end
         ST_BODY: begin
            if (accept) begin
               if (pos_ff < POS_CRC_LO) begin
                  cmd.crc_update = 1'b1;
                  cmd.time_wr    = (pos_ff < POS_TIME);
                  cmd.val_wr     = !(pos_ff < POS_TIME);
                  pos_in         = pos_ff + 1'b1;
               end else if (pos_ff == POS_CRC_LO) begin
                  cmd.crc_lo_wr = 1'b1;
                  pos_in        = pos_ff + 1'b1;
               end else begin
                  // frame close: good CRC starts emission, bad one is dropped
                  pos_in        = '0;
                  idx_in        = '0;
                  cmd.crc_clear = 1'b1;
                  state_in      = ((pos_ff == POS_LAST) && status.crc_match) ?
                                  ST_EMIT : ST_HUNT;
               end
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_load = 1'b1;
               if (idx_ff == IDX_LAST) begin
                  state_in = ST_HUNT;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
         pos_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         idx_ff   <= idx_in;
      end
   end

   // Good frame close always leads into emission
   a_close_to_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BODY && accept && pos_ff == POS_LAST && status.crc_match)
      |=> (state_ff == ST_EMIT))
      else $error("good frame did not start emission");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (idx_ff <= IDX_LAST))
      else $error("emit index out of range");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (pos_ff <= POS_LAST))
      else $error("body position past frame end");

   // Emission ends right after the last joint is loaded
   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_load && cmd.emit_last) |=> (state_ff == ST_HUNT))
      else $error("emission did not end after last joint");

endmodule

// ----- rtl/scfd_dp.sv -----
// ----------------------------------------------------------------------------
// scfd_dp
// Deframer datapath: running CRC, timestamp and joint value storage, and the
// registered result output.
// ----------------------------------------------------------------------------
module scfd_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [7:0]                    req_tdata,
   input  scfd_pkg::ctrl_cmd_type         cmd,
   output scfd_pkg::dp_status_type        status,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [scfd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                          rsp_tlast
);
   import scfd_pkg::*;

   // CRC-16/CCITT-FALSE, MSB first, one byte
   function automatic logic [15:0] crc_add_byte(input logic [15:0] crc,
                                                input logic [7:0]  b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   logic [15:0]         crc_ff, crc_in;
   logic [7:0]          crc_lo_ff;
   logic [7:0]          time_ff [TIME_BYTES];
   logic [VALUE_W-1:0]  value_mem [VALUE_SLOTS];
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic                rsp_last_ff;
   logic [TIME_W-1:0]   time_word;

   always_comb begin
      for (int i = 0; i < TIME_BYTES; i++) begin
         time_word[i*8 +: 8] = time_ff[i];
      end
   end

   assign status.sync_lo   = (req_tdata == SYNC_LO);
   assign status.sync_hi   = (req_tdata == SYNC_HI);
   assign status.crc_match = ({req_tdata, crc_lo_ff} == crc_ff);
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      crc_in = crc_ff;
      if (cmd.crc_clear) begin
         crc_in = CRC_INIT;
      end else if (cmd.crc_update) begin
         crc_in = crc_add_byte(crc_ff, req_tdata);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_INIT;
         crc_lo_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.crc_lo_wr) begin
            crc_lo_ff <= req_tdata;
         end
      end
   end

   // Payload storage and result data register, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.time_wr) begin
         time_ff[cmd.time_lane] <= req_tdata;
      end
      if (cmd.val_wr) begin
         if (cmd.val_hi) begin
            value_mem[cmd.val_slot][15:8] <= req_tdata;
         end else begin
            value_mem[cmd.val_slot][7:0] <= req_tdata;
         end
      end
      if (cmd.emit_load) begin
         rsp_data_ff <= RSP_TDATA_W'({value_mem[cmd.emit_index], cmd.emit_index,
                                      time_word});
         rsp_last_ff <= cmd.emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // A load never overwrites a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten while stalled");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load |=> rsp_tvalid)
      else $error("loaded result not presented");

   a_clear_init: assert property (@(posedge clock) disable iff (reset)
      cmd.crc_clear |=> (crc_ff == CRC_INIT))
      else $error("CRC not restarted");

endmodule

// ----- rtl/sync_crc_frame_deframer_top.sv -----
// ----------------------------------------------------------------------------
// sync_crc_frame_deframer_top
// Sync-word frame deframer: hunts 0x55 0xAA, collects a 38-byte body and
// emits one result per joint when the CRC-16/CCITT-FALSE matches.
// Results: the final CRC byte starts emission; each result is then registered.
// Throughput: one request byte per cycle while hunting or collecting; after a
//   good frame, 14 results at up to one per cycle, during which no request
//   byte is taken.
// Reset: synchronous, active high; returns to sync hunt with an empty output.
// ----------------------------------------------------------------------------
module sync_crc_frame_deframer_top (
   input  logic clock,
   input  logic reset,

   // Request stream: one byte of the framed link per request
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] data_byte

   // Result stream: one joint reading per response
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [63:0] frame_time, [67:64] joint_index, [83:68] joint_value, [87:84] zero
   output logic [scfd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                          rsp_tlast   // last_of_frame
);
   import scfd_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Controller: sync hunt, byte position, emission sequencing
   scfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath: CRC, timestamp, joint values, output register
   scfd_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
